[sv/crpr_pkg.sv]
// Shared constants, codes and handshake structs of the Catmull-Rom path resampler.
`timescale 1ns / 1ps
package crpr_pkg;

    // Field widths fixed by the item format
    localparam int COORD_W   = 32;
    localparam int ACT_W     = 2;
    localparam int SCALE_W   = 16;
    localparam int START_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Datapath widths; sample divisor never exceeds 63
    localparam int DEN_W  = 6;
    localparam int COEF_W = 40;
    localparam int NUM_W  = 57;
    localparam int DIV_W  = 56;
    localparam int DVS_W  = 20;
    localparam int SQ_W   = 61;
    localparam int ROOT_W = 31;

    // Item action codes
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_GENERATE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_INDEX  = 2'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [DVS_W-1:0]  rem;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [SQ_W-1:0]  rad;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] p0;
        logic signed [COORD_W-1:0] p1;
        logic signed [COORD_W-1:0] p2;
        logic signed [COORD_W-1:0] p3;
        logic [DEN_W-1:0]          r;
        logic [DEN_W-1:0]          d;
        logic [2*DEN_W-1:0]        dd;
        logic [3*DEN_W-1:0]        d3;
    } t_cub_req;

    typedef struct packed {
        logic                    done;
        logic signed [NUM_W-1:0] num;
    } t_cub_rsp;

endpackage

[sv/crpr_if.sv]
// Handshake channel interfaces of the Catmull-Rom path resampler.
`timescale 1ns / 1ps
interface crpr_in_if;
    logic                                valid;
    logic                                ready;
    logic [crpr_pkg::ACT_W-1:0]          action;
    logic signed [crpr_pkg::COORD_W-1:0] point_x;
    logic signed [crpr_pkg::COORD_W-1:0] point_y;

    modport source (output valid, output action, output point_x, output point_y, input ready);
    modport sink   (input valid, input action, input point_x, input point_y, output ready);
endinterface

interface crpr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [crpr_pkg::COORD_W-1:0] sample_x;
    logic signed [crpr_pkg::COORD_W-1:0] sample_y;
    logic                                last_sample;

    modport source (output valid, output sample_x, output sample_y, output last_sample,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input last_sample,
                    output ready);
endinterface

interface crpr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [crpr_pkg::CFG_IDX_W-1:0] index;
    logic [crpr_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/catmull_rom_path_resampler.sv]
// Top level of the Catmull-Rom path resampler: store, sequencer and output register.
// Path points arrive as append items and go into a point store with one write and one
// read port; a clear item empties the path and a generate item resamples it. A
// generate item reads the start and last points, takes the distance through a
// bit-serial square root, derives the sample count n, and splits the remaining
// points over n-1 steps with one pass of the shared bit-serial divider. Each sample
// then fetches its four neighbours from the store one per cycle and evaluates x and
// y in turn, each a Horner sequence and a floor division by 2*d^3 on the same
// divider. A finished sample waits in the output register while the next one is
// worked out, and the next item is accepted while the final sample still waits there.
`timescale 1ns / 1ps
module catmull_rom_path_resampler #(
    parameter int MAX_POINTS  = 1024,
    parameter int MAX_SAMPLES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crpr_in_if.sink     i_in,
    crpr_cfg_if.sink    i_cfg,
    crpr_out_if.source  o_out
);

    localparam int PW      = $clog2(MAX_POINTS);
    localparam int CW      = PW + 1;
    localparam int IW      = PW + 2;
    localparam int DENW    = $clog2(MAX_SAMPLES);
    localparam int COORD_W = crpr_pkg::COORD_W;
    localparam int START_W = crpr_pkg::START_W;
    localparam int SCALE_W = crpr_pkg::SCALE_W;
    localparam int DEN_W   = crpr_pkg::DEN_W;
    localparam int DIV_W   = crpr_pkg::DIV_W;
    localparam int DVS_W   = crpr_pkg::DVS_W;
    localparam int NUM_W   = crpr_pkg::NUM_W;
    localparam int ROOT_W  = crpr_pkg::ROOT_W;
    localparam int SQ_W    = crpr_pkg::SQ_W;
    localparam int PROD_W  = ROOT_W + SCALE_W;
    localparam int RAW_W   = PROD_W - 24;
    localparam int VAL_W   = DIV_W + 2;
    localparam int CMP_W   = (CW > START_W) ? CW : START_W;

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_RD_LAST  = 16'h0002,
        ST_RD_START = 16'h0004,
        ST_DIFF     = 16'h0008,
        ST_SQUARE   = 16'h0010,
        ST_SUM      = 16'h0020,
        ST_ROOT     = 16'h0040,
        ST_SCALE    = 16'h0080,
        ST_COUNT    = 16'h0100,
        ST_CUBE     = 16'h0200,
        ST_SEGDIV   = 16'h0400,
        ST_FETCH    = 16'h0800,
        ST_CUBIC    = 16'h1000,
        ST_DIVGO    = 16'h2000,
        ST_DIV      = 16'h4000,
        ST_EMIT     = 16'h8000
    } t_state;

    // Control state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count;
    logic [SCALE_W-1:0] r_scale;
    logic [START_W-1:0] r_start_idx;
    logic               r_ov;

    // Run and sample payload
    logic [PW-1:0]             r_start, r_last, r_m;
    logic signed [COORD_W-1:0] r_lx, r_ly;
    logic [COORD_W:0]          r_ax, r_ay;
    logic                      r_big;
    logic [59:0]               r_sqx, r_sqy;
    logic [PROD_W-1:0]         r_prod;
    logic [DENW-1:0]           r_den, r_rm, r_rem, r_i;
    logic [2*DEN_W-1:0]        r_dd;
    logic [3*DEN_W-1:0]        r_d3;
    logic [PW-1:0]             r_qm, r_seg;
    logic [2:0]                r_fc;
    logic signed [COORD_W-1:0] r_px [4];
    logic signed [COORD_W-1:0] r_py [4];
    logic                      r_coord;
    logic                      r_neg;
    logic [DIV_W-1:0]          r_mag;
    logic signed [COORD_W-1:0] r_sx, r_sy;
    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic                      r_ol;

    // Store access
    logic                      w_we;
    logic [PW-1:0]             w_raddr;
    logic [2*COORD_W-1:0]      w_rdata;
    logic signed [COORD_W-1:0] w_rd_x, w_rd_y;

    crpr_pkg::t_div_req  w_div_req;
    crpr_pkg::t_div_rsp  w_div_rsp;
    crpr_pkg::t_sqrt_req w_sqrt_req;
    crpr_pkg::t_sqrt_rsp w_sqrt_rsp;
    crpr_pkg::t_cub_req  w_cub_req;
    crpr_pkg::t_cub_rsp  w_cub_rsp;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_last_smp;
    logic [CMP_W-1:0]        w_si_ext, w_cnt_ext;
    logic [PW-1:0]           w_start;
    logic signed [COORD_W:0] w_dx, w_dy;
    logic [RAW_W-1:0]        w_raw, w_n;
    logic [IW-1:0]           w_seg_e, w_m_e, w_k0e, w_k1e, w_k2e, w_k3e;
    logic [PW-1:0]           w_k [4];
    logic [DENW:0]           w_rsum;
    logic                    w_wrap;
    logic signed [NUM_W-1:0] w_num;
    logic signed [VAL_W-1:0] w_qs, w_val;
    logic signed [COORD_W-1:0] w_sat, w_p1;
    logic [DEN_W-1:0]        w_den6;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_out_free = !r_ov || o_out.ready;
    assign w_last_smp = (r_i == r_den);
    assign w_den6     = DEN_W'(r_den);

    assign w_rd_x = w_rdata[2*COORD_W-1:COORD_W];
    assign w_rd_y = w_rdata[COORD_W-1:0];

    // Clamp the start point to the stored path
    assign w_si_ext  = CMP_W'(r_start_idx);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_start   = (w_si_ext >= w_cnt_ext) ? PW'(r_count - CW'(1)) : PW'(w_si_ext);

    assign w_we = w_in_acc && (i_in.action == crpr_pkg::ACT_APPEND)
                  && (r_count < CW'(MAX_POINTS));

    crpr_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (PW),
        .DW    (2 * COORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (PW'(r_count)),
        .i_wdata ({i_in.point_x, i_in.point_y}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Neighbour indices, clamped to both ends of the sub-path
    assign w_seg_e = IW'(r_seg);
    assign w_m_e   = IW'(r_m);
    assign w_k1e   = w_seg_e;
    assign w_k0e   = (r_seg == '0) ? '0 : w_seg_e - IW'(1);
    assign w_k2e   = (w_seg_e + IW'(1) > w_m_e) ? w_m_e : w_seg_e + IW'(1);
    assign w_k3e   = (w_seg_e + IW'(2) > w_m_e) ? w_m_e : w_seg_e + IW'(2);
    assign w_k[0]  = r_start + PW'(w_k0e);
    assign w_k[1]  = r_start + PW'(w_k1e);
    assign w_k[2]  = r_start + PW'(w_k2e);
    assign w_k[3]  = r_start + PW'(w_k3e);

    always_comb begin
        w_raddr = r_last;
        if (r_state == ST_RD_START) begin
            w_raddr = r_start;
        end else if (r_state == ST_FETCH) begin
            case (r_fc)
                3'd0:    w_raddr = w_k[0];
                3'd1:    w_raddr = w_k[1];
                3'd2:    w_raddr = w_k[2];
                default: w_raddr = w_k[3];
            endcase
        end
    end

    assign w_dx = (COORD_W+1)'(r_lx) - (COORD_W+1)'(w_rd_x);
    assign w_dy = (COORD_W+1)'(r_ly) - (COORD_W+1)'(w_rd_y);

    // Sample count: distance times scale over 2^24, at least two, at most MAX_SAMPLES
    always_comb begin
        if (r_scale == '0) begin
            w_raw = '0;
        end else if (r_big) begin
            w_raw = RAW_W'(MAX_SAMPLES);
        end else begin
            w_raw = r_prod[PROD_W-1:24];
        end
        if (w_raw < RAW_W'(2)) begin
            w_n = RAW_W'(2);
        end else if (w_raw > RAW_W'(MAX_SAMPLES)) begin
            w_n = RAW_W'(MAX_SAMPLES);
        end else begin
            w_n = w_raw;
        end
    end

    // Step to the next sample: position grows by m, split as quotient and remainder
    assign w_rsum = (DENW+1)'(r_rem) + (DENW+1)'(r_rm);
    assign w_wrap = w_rsum >= (DENW+1)'(r_den);

    assign w_sqrt_req.start = (r_state == ST_SUM);
    assign w_sqrt_req.rad   = SQ_W'(r_sqx) + SQ_W'(r_sqy);

    crpr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sqrt_req),
        .o_rsp   (w_sqrt_rsp)
    );

    // Shared divider: segment split once per run, then floor division per coordinate
    always_comb begin
        w_div_req.start    = (r_state == ST_CUBE) || (r_state == ST_DIVGO);
        w_div_req.dividend = r_mag;
        w_div_req.divisor  = DVS_W'({r_d3, 1'b0});
        if (r_state == ST_CUBE) begin
            w_div_req.dividend = DIV_W'(r_m);
            w_div_req.divisor  = DVS_W'(r_den);
        end
    end

    crpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_cub_req.start = ((r_state == ST_FETCH) && (r_fc == 3'd4))
                           || ((r_state == ST_DIV) && w_div_rsp.done && !r_coord);
    assign w_cub_req.p0 = r_coord ? r_py[0] : r_px[0];
    assign w_cub_req.p1 = r_coord ? r_py[1] : r_px[1];
    assign w_cub_req.p2 = r_coord ? r_py[2] : r_px[2];
    assign w_cub_req.p3 = r_coord ? r_py[3] : r_px[3];
    assign w_cub_req.r  = DEN_W'(r_rem);
    assign w_cub_req.d  = w_den6;
    assign w_cub_req.dd = r_dd;
    assign w_cub_req.d3 = r_d3;

    crpr_cubic u_cubic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cub_req),
        .o_rsp   (w_cub_rsp)
    );

    // Floor division result: undo the magnitude trick, add p1, saturate to 32 bits
    assign w_num = w_cub_rsp.num;
    assign w_qs  = r_neg ? -$signed(VAL_W'(w_div_rsp.quot)) : $signed(VAL_W'(w_div_rsp.quot));
    assign w_p1  = r_coord ? r_py[1] : r_px[1];
    assign w_val = w_qs + VAL_W'(w_p1);

    always_comb begin
        if (w_val[VAL_W-1:COORD_W-1] == '0 || w_val[VAL_W-1:COORD_W-1] == '1) begin
            w_sat = w_val[COORD_W-1:0];
        end else if (w_val[VAL_W-1]) begin
            w_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_in.action == crpr_pkg::ACT_GENERATE && r_count != '0) begin
                    n_state = ST_RD_LAST;
                end
            end
            ST_RD_LAST:  n_state = ST_RD_START;
            ST_RD_START: n_state = ST_DIFF;
            ST_DIFF:     n_state = ST_SQUARE;
            ST_SQUARE:   n_state = ST_SUM;
            ST_SUM:      n_state = ST_ROOT;
            ST_ROOT:     if (w_sqrt_rsp.done) n_state = ST_SCALE;
            ST_SCALE:    n_state = ST_COUNT;
            ST_COUNT:    n_state = ST_CUBE;
            ST_CUBE:     n_state = ST_SEGDIV;
            ST_SEGDIV:   if (w_div_rsp.done) n_state = ST_FETCH;
            ST_FETCH:    if (r_fc == 3'd4) n_state = ST_CUBIC;
            ST_CUBIC:    if (w_cub_rsp.done) n_state = ST_DIVGO;
            ST_DIVGO:    n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = r_coord ? ST_EMIT : ST_CUBIC;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = w_last_smp ? ST_IDLE : ST_FETCH;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_scale     <= crpr_pkg::SCALE_RESET;
            r_start_idx <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && i_in.action == crpr_pkg::ACT_CLEAR) begin
                r_count <= '0;
            end else if (w_we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    crpr_pkg::REG_SAMPLE_SCALE: r_scale     <= i_cfg.data;
                    crpr_pkg::REG_START_INDEX:  r_start_idx <= START_W'(i_cfg.data);
                    default: ;
                endcase
            end
            if (r_state == ST_EMIT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_start <= w_start;
                r_last  <= PW'(r_count - CW'(1));
            end
            ST_RD_START: begin
                r_lx <= w_rd_x;
                r_ly <= w_rd_y;
            end
            ST_DIFF: begin
                r_ax <= w_dx[COORD_W] ? (COORD_W+1)'(-w_dx) : (COORD_W+1)'(w_dx);
                r_ay <= w_dy[COORD_W] ? (COORD_W+1)'(-w_dy) : (COORD_W+1)'(w_dy);
            end
            ST_SQUARE: begin
                r_big <= (|r_ax[COORD_W:30]) || (|r_ay[COORD_W:30]);
                r_sqx <= r_ax[29:0] * r_ax[29:0];
                r_sqy <= r_ay[29:0] * r_ay[29:0];
            end
            ST_SCALE: r_prod <= w_sqrt_rsp.root * r_scale;
            ST_COUNT: begin
                r_den <= DENW'(w_n - RAW_W'(1));
                r_m   <= r_last - r_start;
            end
            ST_CUBE: r_dd <= w_den6 * w_den6;
            ST_SEGDIV: begin
                r_d3 <= r_dd * w_den6;
                if (w_div_rsp.done) begin
                    r_qm  <= PW'(w_div_rsp.quot);
                    r_rm  <= DENW'(w_div_rsp.rem);
                    r_seg <= '0;
                    r_rem <= '0;
                    r_i   <= '0;
                    r_fc  <= '0;
                end
            end
            ST_FETCH: begin
                r_coord <= 1'b0;
                if (r_fc != 3'd4) begin
                    r_fc <= r_fc + 3'd1;
                end
                // read data is registered, so it arrives in the cycle after its address
                case (r_fc)
                    3'd1: begin
                        r_px[0] <= w_rd_x;
                        r_py[0] <= w_rd_y;
                    end
                    3'd2: begin
                        r_px[1] <= w_rd_x;
                        r_py[1] <= w_rd_y;
                    end
                    3'd3: begin
                        r_px[2] <= w_rd_x;
                        r_py[2] <= w_rd_y;
                    end
                    3'd4: begin
                        r_px[3] <= w_rd_x;
                        r_py[3] <= w_rd_y;
                    end
                    default: ;
                endcase
            end
            ST_CUBIC: begin
                if (w_cub_rsp.done) begin
                    r_neg <= w_num[NUM_W-1];
                    // floor for negatives: divide |N| + D - 1 and negate
                    r_mag <= w_num[NUM_W-1]
                           ? DIV_W'(-w_num + $signed(NUM_W'({r_d3, 1'b0})) - NUM_W'(1))
                           : DIV_W'(w_num);
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    if (r_coord) begin
                        r_sy <= w_sat;
                    end else begin
                        r_sx    <= w_sat;
                        r_coord <= 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_ox <= r_sx;
                    r_oy <= r_sy;
                    r_ol <= w_last_smp;
                    r_i  <= r_i + DENW'(1);
                    r_fc <= '0;
                    r_rem <= w_wrap ? DENW'(w_rsum - (DENW+1)'(r_den)) : DENW'(w_rsum);
                    r_seg <= r_seg + r_qm + PW'(w_wrap);
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid       = r_ov;
    assign o_out.sample_x    = r_ox;
    assign o_out.sample_y    = r_oy;
    assign o_out.last_sample = r_ol;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count beyond store capacity");

    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_seg <= r_m && r_rem < r_den && r_i <= r_den))
        else $error("sample position outside the sub-path");

    a_gen_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.action == crpr_pkg::ACT_GENERATE && r_count != '0)
        |=> (r_state == ST_RD_LAST))
        else $error("generate item on a non-empty path did not start a run");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_out_free && w_last_smp)
        |=> (r_state == ST_IDLE && o_out.valid && o_out.last_sample))
        else $error("final sample not flagged or run not closed");

endmodule

[sv/crpr_mem.sv]
// Path point store: one write port, one registered read port.
`timescale 1ns / 1ps
module crpr_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

[sv/crpr_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module crpr_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crpr_pkg::t_div_req i_req,
    output crpr_pkg::t_div_rsp o_rsp
);

    localparam int DIV_W = crpr_pkg::DIV_W;
    localparam int DVS_W = crpr_pkg::DVS_W;
    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic             w_fit;

    assign w_trial = {r_rem, r_q[DIV_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(DIV_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], w_fit};
            r_rem <= w_fit ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

[sv/crpr_sqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module crpr_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crpr_pkg::t_sqrt_req i_req,
    output crpr_pkg::t_sqrt_rsp o_rsp
);

    localparam int RW    = crpr_pkg::SQ_W + 1;
    localparam int STEPS = crpr_pkg::ROOT_W;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RW-1:0]    r_s;
    logic [RW-1:0]    r_r;
    logic [RW-1:0]    r_bit;
    logic [RW-1:0]    w_trial;

    assign w_trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_s   <= RW'(i_req.rad);
            r_r   <= '0;
            r_bit <= RW'(1) << (2 * (STEPS - 1));
        end else if (r_busy) begin
            if (r_s >= w_trial) begin
                r_s <= r_s - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_r[STEPS-1:0];

endmodule

[sv/crpr_cubic.sv]
// Catmull-Rom numerator by Horner steps: (a*r + b*d)*r + c*d*d, times r, plus d^3.
`timescale 1ns / 1ps
module crpr_cubic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crpr_pkg::t_cub_req i_req,
    output crpr_pkg::t_cub_rsp o_rsp
);

    localparam int NUM_W  = crpr_pkg::NUM_W;
    localparam int COEF_W = crpr_pkg::COEF_W;
    localparam int DEN_W  = crpr_pkg::DEN_W;
    localparam int OPB_W  = 2 * DEN_W + 1;
    localparam int PROD_W = NUM_W + OPB_W;

    typedef enum logic [7:0] {
        C_IDLE = 8'b0000_0001,
        C_COEF = 8'b0000_0010,
        C_MUL1 = 8'b0000_0100,
        C_ADD1 = 8'b0000_1000,
        C_MUL2 = 8'b0001_0000,
        C_ADD2 = 8'b0010_0000,
        C_MUL3 = 8'b0100_0000,
        C_FIN  = 8'b1000_0000
    } t_cub_state;

    t_cub_state r_state, n_state;
    logic       r_done;

    logic signed [COEF_W-1:0] w_p0, w_p1, w_p2, w_p3;
    logic signed [COEF_W-1:0] r_a2, r_b2, r_c2;
    logic signed [NUM_W-1:0]  r_t1, r_t2, r_h;
    logic signed [NUM_W-1:0]  w_ma_x, w_mb_x;
    logic signed [OPB_W-1:0]  w_ma_y, w_mb_y;
    logic signed [PROD_W-1:0] w_ma, w_mb;
    logic signed [OPB_W-1:0]  w_r, w_d, w_dd;

    assign w_p0 = COEF_W'(i_req.p0);
    assign w_p1 = COEF_W'(i_req.p1);
    assign w_p2 = COEF_W'(i_req.p2);
    assign w_p3 = COEF_W'(i_req.p3);

    assign w_r  = $signed(OPB_W'(i_req.r));
    assign w_d  = $signed(OPB_W'(i_req.d));
    assign w_dd = $signed(OPB_W'(i_req.dd));

    // Two multipliers, operands picked by step
    always_comb begin
        w_ma_x = r_h;
        w_ma_y = w_r;
        w_mb_x = NUM_W'(r_c2);
        w_mb_y = w_dd;
        if (r_state == C_MUL1) begin
            w_ma_x = NUM_W'(r_a2);
            w_mb_x = NUM_W'(r_b2);
            w_mb_y = w_d;
        end
    end

    assign w_ma = PROD_W'(w_ma_x) * PROD_W'(w_ma_y);
    assign w_mb = PROD_W'(w_mb_x) * PROD_W'(w_mb_y);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (i_req.start) n_state = C_COEF;
            C_COEF:  n_state = C_MUL1;
            C_MUL1:  n_state = C_ADD1;
            C_ADD1:  n_state = C_MUL2;
            C_MUL2:  n_state = C_ADD2;
            C_ADD2:  n_state = C_MUL3;
            C_MUL3:  n_state = C_FIN;
            C_FIN:   n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == C_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_COEF: begin
                r_a2 <= w_p3 - w_p0 + 3 * (w_p1 - w_p2);
                r_b2 <= 2 * w_p0 - 5 * w_p1 + 4 * w_p2 - w_p3;
                r_c2 <= w_p2 - w_p0;
            end
            C_MUL1: begin
                r_t1 <= w_ma[NUM_W-1:0];
                r_t2 <= w_mb[NUM_W-1:0];
            end
            C_ADD1: r_h <= r_t1 + r_t2;
            C_MUL2: begin
                r_h  <= w_ma[NUM_W-1:0];
                r_t2 <= w_mb[NUM_W-1:0];
            end
            C_ADD2: r_h <= r_h + r_t2;
            C_MUL3: r_h <= w_ma[NUM_W-1:0];
            C_FIN:  r_h <= r_h + $signed(NUM_W'(i_req.d3));
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.num  = r_h;

endmodule
